/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SDF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sdf assertion failed");

// Next-cycle implication
`define SDF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sdf assertion failed");

`endif

/* rtl/sdf_pkg.sv */
// ----------------------------------------------------------------------------
// sdf_pkg
// Types and constants shared by the signed decimal formatter.
// ----------------------------------------------------------------------------
package sdf_pkg;

	localparam int ValueW    = 32;
	localparam int CharW     = 7;
	localparam int NumDigits = 10;
	localparam int BcdW      = NumDigits * 4;
	localparam int CntW      = $clog2(ValueW);
	localparam int DigIdxW   = $clog2(NumDigits);

	localparam logic [CharW-1:0] ChMinus = 7'd45;
	localparam logic [CharW-1:0] ChZero  = 7'd48;
	localparam logic [CharW-1:0] ChNine  = 7'd57;
	localparam logic [CharW-1:0] ChLf    = 7'd10;
	localparam logic [CharW-1:0] ChCr    = 7'd13;

	typedef logic [NumDigits-1:0][3:0] bcd_t;

	// Sequencer states of the top level
	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_SIGN,
		S_DIGIT,
		S_LF,
		S_CR
	} state_t;

	// Top level to converter
	typedef struct packed {
		logic              start;
		logic [ValueW-1:0] operand;
	} conv_ctrl_t;

	// Converter to top level
	typedef struct packed {
		logic done;
		bcd_t digits;
	} conv_stat_t;

endpackage

/* rtl/sdf_bcd_conv.sv */
// ----------------------------------------------------------------------------
// sdf_bcd_conv
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle.
// ----------------------------------------------------------------------------
module sdf_bcd_conv (
	input  logic                clk,
	input  logic                arst_n,
	input  sdf_pkg::conv_ctrl_t ctrl,
	output sdf_pkg::conv_stat_t stat
);

	logic [sdf_pkg::ValueW-1:0] bin_q;
	sdf_pkg::bcd_t              bcd_q;
	sdf_pkg::bcd_t              adj;
	logic [sdf_pkg::BcdW-1:0]   adj_flat;
	logic [sdf_pkg::CntW-1:0]   cnt_q;
	logic                       busy_q;
	logic                       done_q;

	// Add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < sdf_pkg::NumDigits; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end
	assign adj_flat = adj;

	// Control: step counter, busy and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sdf_pkg::CntW'(sdf_pkg::ValueW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: binary shifts out MSB first into the BCD register
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			bin_q <= ctrl.operand;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[sdf_pkg::ValueW-2:0], 1'b0};
			bcd_q <= {adj_flat[sdf_pkg::BcdW-2:0], bin_q[sdf_pkg::ValueW-1]};
		end
	end

	assign stat.done   = done_q;
	assign stat.digits = bcd_q;

endmodule

/* rtl/signed_decimal_formatter_top.sv */
// ----------------------------------------------------------------------------
// signed_decimal_formatter_top
// Prints a signed 32-bit integer as ASCII decimal text, one character per
// output item: optional '-', digits most significant first without leading
// zeros (zero prints as "0"), then line feed and carriage return, the
// carriage return flagged with last. The most negative value prints as
// -2147483648. One number is handled at a time: after acceptance the
// magnitude goes through a 32-step shift-and-add-3 converter (one step per
// cycle), then one character is issued per cycle while the output is taken;
// in_ready returns once the carriage return is loaded.
// ----------------------------------------------------------------------------
module signed_decimal_formatter_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [31:0]         value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [sdf_pkg::CharW-1:0]  char_code,
	output logic                       last
);

	sdf_pkg::state_t             state_q, state_d;
	sdf_pkg::conv_ctrl_t         conv_ctrl;
	sdf_pkg::conv_stat_t         conv_stat;
	logic                        neg_q;
	logic [sdf_pkg::DigIdxW-1:0] dig_q;
	logic [sdf_pkg::DigIdxW-1:0] lead_idx;
	logic [sdf_pkg::ValueW-1:0]  mag;
	logic [3:0]                  cur_digit;
	logic                        accept;
	logic                        slot_free;
	logic                        load_out;
	logic [sdf_pkg::CharW-1:0]   load_char;
	logic                        load_last;
	logic                        out_valid_q;
	logic [sdf_pkg::CharW-1:0]   char_q;
	logic                        last_q;

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// Magnitude; the most negative value wraps to 2^31 as unsigned
	assign mag = value[31] ? (~$unsigned(value) + 1'b1) : $unsigned(value);

	assign conv_ctrl.start   = accept;
	assign conv_ctrl.operand = mag;

	sdf_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (conv_ctrl),
		.stat   (conv_stat)
	);

	// Highest nonzero digit, zero when all digits are zero
	always_comb begin
		lead_idx = '0;
		for (int i = 1; i < sdf_pkg::NumDigits; i++) begin
			if (conv_stat.digits[i] != 4'd0) begin
				lead_idx = sdf_pkg::DigIdxW'(i);
			end
		end
	end

	assign cur_digit = conv_stat.digits[dig_q];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sdf_pkg::S_IDLE:  if (accept) state_d = sdf_pkg::S_CONV;
			sdf_pkg::S_CONV: begin
				if (conv_stat.done) begin
					state_d = neg_q ? sdf_pkg::S_SIGN : sdf_pkg::S_DIGIT;
				end
			end
			sdf_pkg::S_SIGN:  if (slot_free) state_d = sdf_pkg::S_DIGIT;
			sdf_pkg::S_DIGIT: if (slot_free && dig_q == '0) state_d = sdf_pkg::S_LF;
			sdf_pkg::S_LF:    if (slot_free) state_d = sdf_pkg::S_CR;
			sdf_pkg::S_CR:    if (slot_free) state_d = sdf_pkg::S_IDLE;
			default:          state_d = sdf_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		load_out  = 1'b0;
		load_char = sdf_pkg::ChZero;
		load_last = 1'b0;
		unique case (state_q)
			sdf_pkg::S_IDLE: in_ready = 1'b1;
			sdf_pkg::S_CONV: ;
			sdf_pkg::S_SIGN: begin
				load_out  = slot_free;
				load_char = sdf_pkg::ChMinus;
			end
			sdf_pkg::S_DIGIT: begin
				load_out  = slot_free;
				load_char = sdf_pkg::ChZero + {3'b000, cur_digit};
			end
			sdf_pkg::S_LF: begin
				load_out  = slot_free;
				load_char = sdf_pkg::ChLf;
			end
			sdf_pkg::S_CR: begin
				load_out  = slot_free;
				load_char = sdf_pkg::ChCr;
				load_last = 1'b1;
			end
			default: ;
		endcase
	end

	// State, sign and digit pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdf_pkg::S_IDLE;
			neg_q   <= 1'b0;
			dig_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				neg_q <= value[31];
			end
			if (state_q == sdf_pkg::S_CONV && conv_stat.done) begin
				dig_q <= lead_idx;
			end else if (state_q == sdf_pkg::S_DIGIT && slot_free && dig_q != '0) begin
				dig_q <= dig_q - 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			char_q <= load_char;
			last_q <= load_last;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

endmodule

/* rtl/sdf_checker.sv */
// ----------------------------------------------------------------------------
// sdf_checker
// Port-level checks of the signed decimal formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdf_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [sdf_pkg::CharW-1:0] char_code,
	input logic                      last
);

	// The end-of-number flag only rides on a carriage return
	`SDF_ASSERT_NOW(a_last_is_cr, out_valid && last, char_code == sdf_pkg::ChCr)

	// Every other character is a sign, a digit or a line feed
	`SDF_ASSERT_NOW(a_char_legal, out_valid && !last, char_code == sdf_pkg::ChMinus || char_code == sdf_pkg::ChLf || (char_code >= sdf_pkg::ChZero && char_code <= sdf_pkg::ChNine))

	// One number at a time: no new item right after one is taken
	`SDF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// A stalled character holds
	`SDF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(char_code) && $stable(last))

endmodule

bind signed_decimal_formatter_top sdf_checker u_sdf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.char_code (char_code),
	.last      (last)
);

/* verif/tb_signed_decimal_formatter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_decimal_formatter_top
// Sends signed 32-bit integers into the formatter and checks each character
// it prints (sign, digits, line feed, carriage return with last) against a
// local prediction of the decimal text. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_signed_decimal_formatter_top;

	// One printed character
	typedef struct packed {
		logic [sdf_pkg::CharW-1:0] code;
		logic                      last;
	} char_item_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic signed [sdf_pkg::ValueW-1:0] value = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [sdf_pkg::CharW-1:0]         char_code;
	logic                              last;

	logic [sdf_pkg::ValueW-1:0] pending_values[$];
	char_item_t                 expected_chars[$];
	char_item_t                 exp_char;
	int                         errors = 0;
	int                         items_sent = 0;
	int                         chars_seen = 0;
	int                         send_gap = 0;
	int                         stall_left = 0;
	int                         stall_pick;

	signed_decimal_formatter_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Expected text of one number: sign, digits MSD first, LF, CR
	function automatic void queue_decimal_text(input logic [sdf_pkg::ValueW-1:0] num);
		logic [sdf_pkg::ValueW-1:0] mag;
		logic [sdf_pkg::ValueW-1:0] digit_buf[sdf_pkg::NumDigits];
		int                         ndig;
		char_item_t                 ch;
		ndig = 0;
		if (num[sdf_pkg::ValueW-1]) begin
			ch.code = sdf_pkg::ChMinus;
			ch.last = 1'b0;
			expected_chars.push_back(ch);
			mag = 32'd0 - num;
		end else begin
			mag = num;
		end
		do begin
			digit_buf[ndig] = mag % 10;
			mag = mag / 10;
			ndig++;
		end while (mag != 0 && ndig < sdf_pkg::NumDigits);
		while (ndig > 0) begin
			ndig--;
			ch.code = sdf_pkg::ChZero + digit_buf[ndig][sdf_pkg::CharW-1:0];
			ch.last = 1'b0;
			expected_chars.push_back(ch);
		end
		ch.code = sdf_pkg::ChLf;
		ch.last = 1'b0;
		expected_chars.push_back(ch);
		ch.code = sdf_pkg::ChCr;
		ch.last = 1'b1;
		expected_chars.push_back(ch);
	endfunction

	// Idle length: none in calm stretches, else mostly short, a few long
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Input driver: presents pending values, idles between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value    <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				queue_decimal_text(value);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_values.size() > 0) begin
					value      <= pending_values.pop_front();
					in_valid   <= 1'b1;
					items_sent <= items_sent + 1;
					send_gap   <= pick_gap(((items_sent / 30) % 3) == 0);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each character, stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				chars_seen <= chars_seen + 1;
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected item: char_code %0d last %0b",
						$time, char_code, last);
					errors++;
				end else begin
					exp_char = expected_chars.pop_front();
					if (char_code !== exp_char.code) begin
						$display("%0t: char_code mismatch: expected %0d, got %0d",
							$time, exp_char.code, char_code);
						errors++;
					end
					if (last !== exp_char.last) begin
						$display("%0t: last mismatch: expected %0b, got %0b",
							$time, exp_char.last, last);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				out_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else if ((out_valid && out_ready)
					|| (!out_valid && $urandom_range(0, 7) == 0)) begin
				stall_pick = pick_gap(((chars_seen / 100) % 3) == 0);
				if (stall_pick == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready  <= 1'b0;
					stall_left <= stall_pick - 1;
				end
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		logic [sdf_pkg::ValueW-1:0] rnd;

		// Directed: zero, sign edges, digit-count edges, extremes
		pending_values.push_back(32'd0);
		pending_values.push_back(32'd1);
		pending_values.push_back(-32'sd1);
		pending_values.push_back(32'd5);
		pending_values.push_back(-32'sd5);
		pending_values.push_back(32'd9);
		pending_values.push_back(32'd10);
		pending_values.push_back(-32'sd10);
		pending_values.push_back(32'd99);
		pending_values.push_back(32'd100);
		pending_values.push_back(32'd123456789);
		pending_values.push_back(32'd999999999);
		pending_values.push_back(32'd1000000000);
		pending_values.push_back(-32'sd1000000000);
		pending_values.push_back(32'd1999999999);
		pending_values.push_back(32'h7FFF_FFFF);
		pending_values.push_back(32'h8000_0000);
		pending_values.push_back(32'h8000_0001);
		pending_values.push_back(32'h5555_5555);
		pending_values.push_back(32'hAAAA_AAAA);
		pending_values.push_back(32'd0);

		// Random: spread over all lengths and both signs
		for (int i = 0; i < 189; i++) begin
			rnd = $urandom;
			rnd = rnd >> $urandom_range(0, 31);
			if ($urandom_range(0, 1))
				rnd = 32'd0 - rnd;
			pending_values.push_back(rnd);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending_values.size() != 0 || in_valid || expected_chars.size() != 0);
		repeat (60) @(posedge clk);

		if (errors == 0)
			$display("[signed_decimal_formatter_top] OK");
		else
			$display("[signed_decimal_formatter_top] ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#10ms;
		$display("%0t: timeout", $time);
		$display("[signed_decimal_formatter_top] ERROR");
		$finish;
	end

endmodule
